@@ hw/rtl/mke_pkg.sv @@
package mke_pkg;

  localparam int unsigned DurW       = 18;
  localparam int unsigned DotW       = 10;
  localparam int unsigned UnitW      = 8;
  localparam int unsigned JobQDepth  = 2;
  localparam int unsigned JobQPtrW   = 1;
  localparam int unsigned JobQCntW   = 2;

  localparam logic [UnitW-1:0] DotUnits       = 8'd1;
  localparam logic [UnitW-1:0] DashUnits      = 8'd3;
  localparam logic [UnitW-1:0] SymbolGapUnits = 8'd1;
  localparam logic [UnitW-1:0] LetterGapUnits = 8'd3;
  localparam logic [UnitW-1:0] WordGapUnits   = 8'd7;

  localparam logic [DotW-1:0]  DotTicksRst  = 10'd100;
  localparam logic [UnitW-1:0] GapUnitsRst  = 8'd50;

  // register index, held in paddr[2]
  localparam logic RegDotTicks = 1'b0;
  localparam logic RegGapUnits = 1'b1;

  localparam logic [6:0] CharSpace = 7'h20;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharNine  = 7'h39;
  localparam logic [6:0] CharA     = 7'h41;
  localparam logic [6:0] CharZ     = 7'h5A;

  typedef struct packed {
    logic [6:0] char_code;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic            led_on;
    logic [DurW-1:0] duration_ticks;
    logic            bad_char;
    logic            last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_CODE,
    KIND_SPACE,
    KIND_BAD
  } kind_e;

  // symbols are msb first, 1 is a dash
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pat;
  } code_t;

  typedef struct packed {
    kind_e kind;
    logic  letter_gap;
    code_t code;
    logic  eom;
  } job_t;

  function automatic code_t letter_code(logic [4:0] idx);
    code_t c;
    case (idx)
      5'd0:  c = '{3'd2, 5'b01000};
      5'd1:  c = '{3'd4, 5'b10000};
      5'd2:  c = '{3'd4, 5'b10100};
      5'd3:  c = '{3'd3, 5'b10000};
      5'd4:  c = '{3'd1, 5'b00000};
      5'd5:  c = '{3'd4, 5'b00100};
      5'd6:  c = '{3'd3, 5'b11000};
      5'd7:  c = '{3'd4, 5'b00000};
      5'd8:  c = '{3'd2, 5'b00000};
      5'd9:  c = '{3'd4, 5'b01110};
      5'd10: c = '{3'd3, 5'b10100};
      5'd11: c = '{3'd4, 5'b01000};
      5'd12: c = '{3'd2, 5'b11000};
      5'd13: c = '{3'd2, 5'b10000};
      5'd14: c = '{3'd3, 5'b11100};
      5'd15: c = '{3'd4, 5'b01100};
      5'd16: c = '{3'd4, 5'b11010};
      5'd17: c = '{3'd3, 5'b01000};
      5'd18: c = '{3'd3, 5'b00000};
      5'd19: c = '{3'd1, 5'b10000};
      5'd20: c = '{3'd3, 5'b00100};
      5'd21: c = '{3'd4, 5'b00010};
      5'd22: c = '{3'd3, 5'b01100};
      5'd23: c = '{3'd4, 5'b10010};
      5'd24: c = '{3'd4, 5'b10110};
      5'd25: c = '{3'd4, 5'b11000};
      default: c = '{3'd1, 5'b00000};
    endcase
    return c;
  endfunction

  function automatic code_t digit_code(logic [3:0] idx);
    code_t c;
    case (idx)
      4'd0: c = '{3'd5, 5'b11111};
      4'd1: c = '{3'd5, 5'b01111};
      4'd2: c = '{3'd5, 5'b00111};
      4'd3: c = '{3'd5, 5'b00011};
      4'd4: c = '{3'd5, 5'b00001};
      4'd5: c = '{3'd5, 5'b00000};
      4'd6: c = '{3'd5, 5'b10000};
      4'd7: c = '{3'd5, 5'b11000};
      4'd8: c = '{3'd5, 5'b11100};
      4'd9: c = '{3'd5, 5'b11110};
      default: c = '{3'd5, 5'b00000};
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/mke_front.sv @@
module mke_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mke_pkg::in_item_t item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output mke_pkg::job_t     job_o
);
  import mke_pkg::*;

  logic       after_letter_q, after_letter_d;
  logic [6:0] c;
  logic       is_letter, is_digit, is_space;
  logic       accept;

  assign c         = item_i.char_code;
  assign is_letter = (c >= CharA) && (c <= CharZ);
  assign is_digit  = (c >= CharZero) && (c <= CharNine);
  assign is_space  = (c == CharSpace);
  assign accept    = push_i && !q_full_i;
  assign q_push_o  = accept;

  always_comb begin
    job_o.kind       = KIND_BAD;
    job_o.letter_gap = 1'b0;
    job_o.code       = letter_code(5'(c - CharA));
    job_o.eom        = item_i.end_of_message;
    after_letter_d   = after_letter_q;
    if (is_space) begin
      job_o.kind     = KIND_SPACE;
      after_letter_d = 1'b0;
    end else if (is_letter || is_digit) begin
      job_o.kind       = KIND_CODE;
      job_o.letter_gap = after_letter_q;
      if (is_digit) begin
        job_o.code = digit_code(4'(c - CharZero));
      end
      after_letter_d = 1'b1;
    end
    if (item_i.end_of_message) begin
      after_letter_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_letter_q <= 1'b0;
    end else if (accept) begin
      after_letter_q <= after_letter_d;
    end
  end

endmodule

@@ hw/rtl/mke_fifo.sv @@
module mke_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mke_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output mke_pkg::job_t rdata_o,
  output logic          empty_o
);
  import mke_pkg::*;

  job_t                mem_q [JobQDepth];
  logic [JobQPtrW-1:0] wptr_q, rptr_q;
  logic [JobQCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == JobQCntW'(JobQDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/mke_back.sv @@
module mke_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [mke_pkg::DotW-1:0] dot_ticks_i,
  input  logic [mke_pkg::UnitW-1:0] gap_units_i,
  input  logic                     q_empty_i,
  input  mke_pkg::job_t            job_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  output mke_pkg::out_item_t       out_item_o,
  input  logic                     out_pop_i
);
  import mke_pkg::*;

  typedef enum logic [2:0] {
    PH_LGAP,
    PH_SYM,
    PH_SGAP,
    PH_WORD,
    PH_BAD,
    PH_EOM
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             busy_q;
  logic [2:0]       rem_q;
  logic [4:0]       pat_q;
  logic             eom_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic             adv, emit, finish, done, load, end_body;
  logic             seg_on, seg_bad;
  logic [UnitW-1:0] seg_units;
  phase_e           first_phase;

  assign adv     = !out_valid_q || out_pop_i;
  assign emit    = busy_q && adv;
  assign done    = emit && finish;
  assign load    = (!busy_q || done) && !q_empty_i;
  assign q_pop_o = load;

  always_comb begin
    seg_on    = 1'b0;
    seg_bad   = 1'b0;
    seg_units = SymbolGapUnits;
    end_body  = 1'b0;
    finish    = 1'b0;
    phase_d   = phase_q;
    case (phase_q)
      PH_LGAP: begin
        seg_units = LetterGapUnits;
        phase_d   = PH_SYM;
      end
      PH_SYM: begin
        seg_on    = 1'b1;
        seg_units = pat_q[4] ? DashUnits : DotUnits;
        if (rem_q == 3'd1) begin
          end_body = 1'b1;
        end else begin
          phase_d = PH_SGAP;
        end
      end
      PH_SGAP: begin
        seg_units = SymbolGapUnits;
        phase_d   = PH_SYM;
      end
      PH_WORD: begin
        seg_units = WordGapUnits;
        end_body  = 1'b1;
      end
      PH_BAD: begin
        seg_units = '0;
        seg_bad   = 1'b1;
        end_body  = 1'b1;
      end
      PH_EOM: begin
        seg_units = gap_units_i;
        finish    = 1'b1;
      end
      default: begin
        seg_units = gap_units_i;
        finish    = 1'b1;
      end
    endcase
    // message gap follows the body when the character closes a message
    if (end_body) begin
      if (eom_q) begin
        phase_d = PH_EOM;
      end else begin
        finish = 1'b1;
      end
    end
  end

  always_comb begin
    case (job_i.kind)
      KIND_SPACE: first_phase = PH_WORD;
      KIND_CODE:  first_phase = job_i.letter_gap ? PH_LGAP : PH_SYM;
      default:    first_phase = PH_BAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_BAD;
      busy_q      <= 1'b0;
      rem_q       <= '0;
      pat_q       <= '0;
      eom_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (emit) begin
        out_valid_q          <= 1'b1;
        out_q.led_on         <= seg_on;
        out_q.duration_ticks <= DurW'(seg_units) * DurW'(dot_ticks_i);
        out_q.bad_char       <= seg_bad;
        out_q.last           <= finish;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end

      if (load) begin
        busy_q  <= 1'b1;
        phase_q <= first_phase;
        rem_q   <= job_i.code.len;
        pat_q   <= job_i.code.pat;
        eom_q   <= job_i.eom;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        phase_q <= phase_d;
        if (phase_q == PH_SYM) begin
          rem_q <= rem_q - 1'b1;
          pat_q <= {pat_q[3:0], 1'b0};
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hw/rtl/morse_keyer_encoder.sv @@
// order: a pushed character is written to the job queue, loaded into the back
// sequencer and then registered as its first segment on the result ports
// throughput: one segment per cycle from the back sequencer while the result
// is empty or popped; a character has 1 to 11 segments, with no gap between them
// reset: async active low; job queue and result empty, dot_ticks 100, gap 50
module morse_keyer_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  mke_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output mke_pkg::out_item_t out_item_o
);
  import mke_pkg::*;

  logic [DotW-1:0]  dot_ticks_q;
  logic [UnitW-1:0] gap_units_q;
  logic             cfg_wr;
  logic             q_push, q_pop, q_full, q_empty, out_valid;
  job_t             job_in, job_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ticks_q <= DotTicksRst;
      gap_units_q <= GapUnitsRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegDotTicks: dot_ticks_q <= pwdata[DotW-1:0];
        RegGapUnits: gap_units_q <= pwdata[UnitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegDotTicks: prdata = 32'(dot_ticks_q);
      RegGapUnits: prdata = 32'(gap_units_q);
      default:     prdata = '0;
    endcase
  end

  mke_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (in_item_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .job_o    (job_in)
  );

  mke_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (job_out),
    .empty_o (q_empty)
  );

  mke_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dot_ticks_i (dot_ticks_q),
    .gap_units_i (gap_units_q),
    .q_empty_i   (q_empty),
    .job_i       (job_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o),
    .out_pop_i   (pop)
  );

  assign full  = q_full;
  assign empty = !out_valid;

endmodule

@@ hw/rtl/mke_checker.sv @@
module mke_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input mke_pkg::out_item_t out_item_o
);
  import mke_pkg::*;

  // a waiting item holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("result changed while stalled");

  a_bad_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.bad_char |-> !out_item_o.led_on
      && out_item_o.duration_ticks == '0)
    else $error("error item is not a dark zero-length segment");

  // two marks are always parted by an off segment
  a_no_double_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && out_item_o.led_on |=> empty || !out_item_o.led_on)
    else $error("two marks in a row");

  // an error item not closing its character is followed by the message gap
  a_bad_then_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && out_item_o.bad_char && !out_item_o.last |=>
      empty || (out_item_o.last && !out_item_o.bad_char && !out_item_o.led_on))
    else $error("error item not followed by message gap");

endmodule

bind morse_keyer_encoder mke_checker u_mke_checker (.*);
